### rtl/isq_pkg.sv
package isq_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned POS_W    = 9;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STAT_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ = 3'd0,
    KIND_HEAD = 3'd1,
    KIND_TAIL = 3'd2,
    KIND_AT   = 3'd3,
    KIND_DEL  = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;      // latch the incoming request
    logic eval;         // latch the status code of the request
    logic rd_pos;       // read the entry at the request position
    logic start_shift;  // load the shift pointer
    logic shift_rd;     // read one entry of the shift, advance the pointer
    logic final_op;     // place the new value / adjust the count
    logic load_result;  // fill the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_read;
    logic op_ins;
    logic op_del;
    logic err;          // out of range or full
    logic no_shift;     // nothing to move
    logic shift_last;   // pointer is on the last entry to move
    logic out_free;     // output register can take a result
  } stat_t;

endpackage

### rtl/isq_ctrl.sv
module isq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  isq_pkg::stat_t  stat_i,
  output isq_pkg::cmd_t   cmd_o
);
  import isq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_DRAIN = 6'b001000,
    S_FINAL = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (stat_i.err) begin
          state_d = S_RESP;
        end else if (stat_i.op_read) begin
          cmd_o.rd_pos = 1'b1;
          state_d      = S_RESP;
        end else if (stat_i.op_ins || stat_i.op_del) begin
          if (stat_i.no_shift) begin
            state_d = S_FINAL;
          end else begin
            cmd_o.start_shift = 1'b1;
            state_d           = S_SHIFT;
          end
        end else begin
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_rd = 1'b1;
        if (stat_i.shift_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_FINAL;
      end
      S_FINAL: begin
        cmd_o.final_op = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/isq_dpath.sv
module isq_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  isq_pkg::cmd_t                        cmd_i,
  output isq_pkg::stat_t                       stat_o,
  input  logic [isq_pkg::KIND_W-1:0]           kind_i,
  input  logic [isq_pkg::POS_W-1:0]            position_i,
  input  logic signed [isq_pkg::DATA_W-1:0]    value_i,
  input  logic                                 m_ready_i,
  output logic                                 m_valid_o,
  output logic signed [isq_pkg::DATA_W-1:0]    read_value_o,
  output logic [isq_pkg::STAT_W-1:0]           status_o,
  output logic [isq_pkg::POS_W-1:0]            length_o
);
  import isq_pkg::*;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  kind_e                    kind_q;
  logic [POS_W-1:0]         pos_q, count_q, count_d;
  logic [POS_W-1:0]         rd_ptr_q, wr_addr_q;
  logic signed [DATA_W-1:0] value_q, rdata_q;
  logic                     wr_pend_q;
  status_e                  st_q, st_d;
  logic signed [DATA_W-1:0] rv_q;
  logic [STAT_W-1:0]        res_st_q;
  logic [POS_W-1:0]         len_q;
  logic                     out_valid_q;

  logic                     is_read, is_ins, is_del;
  logic                     rng_err, full_err;
  logic [POS_W-1:0]         eff_pos;
  logic [POS_W:0]           pos_inc, ptr_inc, count_ext;
  logic                     rd_en, wr_en;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  assign is_read = (kind_q == KIND_READ);
  assign is_ins  = (kind_q == KIND_HEAD) || (kind_q == KIND_TAIL) || (kind_q == KIND_AT);
  assign is_del  = (kind_q == KIND_DEL);

  assign pos_inc   = (POS_W+1)'(pos_q) + 1'b1;
  assign ptr_inc   = (POS_W+1)'(rd_ptr_q) + 1'b1;
  assign count_ext = (POS_W+1)'(count_q);

  assign rng_err  = ((is_read || is_del) && (pos_q >= count_q)) || (is_ins && (pos_q > count_q));
  assign full_err = is_ins && !rng_err && (count_q == POS_W'(CAPACITY));
  assign st_d     = rng_err ? ST_RANGE : (full_err ? ST_FULL : ST_DONE);

  assign stat_o.op_read    = is_read;
  assign stat_o.op_ins     = is_ins;
  assign stat_o.op_del     = is_del;
  assign stat_o.err        = rng_err || full_err;
  assign stat_o.no_shift   = is_ins ? (pos_q == count_q) : (pos_inc == count_ext);
  assign stat_o.shift_last = is_ins ? (rd_ptr_q == pos_q) : (ptr_inc == count_ext);
  assign stat_o.out_free   = !out_valid_q || m_ready_i;

  // head and tail inserts resolve to a position at capture
  always_comb begin
    case (kind_i)
      KIND_HEAD: eff_pos = '0;
      KIND_TAIL: eff_pos = count_q;
      default:   eff_pos = position_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_e'(kind_i);
      pos_q   <= eff_pos;
      value_q <= value_i;
    end
    if (cmd_i.eval) st_q <= st_d;
    if (cmd_i.start_shift) begin
      rd_ptr_q <= is_ins ? count_q - 1'b1 : POS_W'(pos_inc);
    end else if (cmd_i.shift_rd) begin
      rd_ptr_q <= is_ins ? rd_ptr_q - 1'b1 : POS_W'(ptr_inc);
    end
    if (cmd_i.shift_rd) begin
      wr_addr_q <= is_ins ? POS_W'(ptr_inc) : rd_ptr_q - 1'b1;
    end
    if (cmd_i.load_result) begin
      if (is_read) begin
        rv_q <= (st_q == ST_RANGE) ? -32'sd1 : rdata_q;
      end else begin
        rv_q <= '0;
      end
      res_st_q <= st_q;
      len_q    <= count_q;
    end
  end

  // single memory: one write and one registered read per cycle
  assign rd_en   = cmd_i.shift_rd || cmd_i.rd_pos;
  assign rd_addr = cmd_i.shift_rd ? rd_ptr_q[ADDR_W-1:0] : pos_q[ADDR_W-1:0];
  assign wr_en   = wr_pend_q || (cmd_i.final_op && is_ins);
  assign wr_addr = wr_pend_q ? wr_addr_q[ADDR_W-1:0] : pos_q[ADDR_W-1:0];
  assign wr_data = wr_pend_q ? rdata_q : value_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.final_op) begin
      count_d = is_ins ? count_q + 1'b1 : count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      wr_pend_q <= cmd_i.shift_rd;
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o    = out_valid_q;
  assign read_value_o = rv_q;
  assign status_o     = res_st_q;
  assign length_o     = len_q;

endmodule

### rtl/indexed_sequence_store_unit.sv
// Sequence: a read or a refused request goes from acceptance through evaluation to the
//   result; an insert or delete that moves k entries (k from 1 to CAPACITY-1) adds the
//   shift, a drain step and the final write, and one that moves no entry skips the first two.
// Throughput: one request at a time; the shift moves one entry per cycle through the
//   single entry memory (one read, one write per cycle).
// Reset: entry count and handshake state clear; entries keep no reset and need no sweep.
module indexed_sequence_store_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // [8:0] position, [40:9] value, rest zero
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] kind
  // result channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] read_value, [40:32] length, rest zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);
  import isq_pkg::*;

  cmd_t                     cmd;
  stat_t                    stat;
  logic                     s_ready;
  logic signed [DATA_W-1:0] read_value;
  logic [POS_W-1:0]         length;

  // Sequencer: accept, evaluate, shift loop, final write, result hand-off.
  isq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Entry memory, count, shift pointers and the output register.
  isq_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (s_axis_tuser_i),
    .position_i   (s_axis_tdata_i[POS_W-1:0]),
    .value_i      (s_axis_tdata_i[POS_W+DATA_W-1:POS_W]),
    .m_ready_i    (m_axis_tready_i),
    .m_valid_o    (m_axis_tvalid_o),
    .read_value_o (read_value),
    .status_o     (m_axis_tuser_o),
    .length_o     (length)
  );

  assign s_axis_tready_o = s_ready;
  assign m_axis_tdata_o  = {7'b0, length, read_value};

  // the request is accepted only while nothing is moving in the memory
  a_idle_no_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !cmd.shift_rd && !cmd.final_op)
    else $error("request port open during an operation");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken back to back");

  // a refused request never moves entries
  a_err_no_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.eval && stat.err |=> !cmd.shift_rd && !cmd.final_op)
    else $error("refused request changed the store");

  // reported length stays within capacity
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[40:32] <= POS_W'(CAPACITY))
    else $error("length past capacity");

endmodule
